// File: rtl/core/capm_pkg.sv
// Shared types and constants for the circular aperture pixel mask.
`default_nettype none

package capm_pkg;

  // Fixed field widths
  localparam int unsigned FUNC_W    = 1;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned POS_W     = 18;
  localparam int unsigned AREA_W    = 24;
  localparam int unsigned ROOT_W    = 12;
  localparam int unsigned RADIUS_W  = 13;
  localparam int unsigned PIXEL_W   = 16;
  localparam int unsigned SIZE_W    = 15;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 15;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_APERTURE_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RADIUS     = 3'd3;

  // Register reset values
  localparam logic [SIZE_W-1:0]   SIZE_RESET       = 15'd1024;
  localparam logic [COUNT_W-1:0]  COUNT_RESET      = 7'd0;
  localparam logic [RADIUS_W-1:0] MIN_RADIUS_RESET = 13'd35;

  // Item function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_PIXEL = 1'b1;

  // First bit weight of the root iteration (even power, top of the area range)
  localparam logic [AREA_W-1:0] ROOT_FIRST_BIT = 24'h40_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROOT,
    ST_PIX
  } state_e;

  // Status of the distance pipeline
  typedef struct packed {
    logic busy;
    logic hit_valid;
    logic hit;
  } dist_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/capm_isqrt.sv
// Iterative integer square root of the area, one root bit per cycle.
`default_nettype none

module capm_isqrt (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [capm_pkg::AREA_W-1:0]    value_i,
  output logic                                done_o,
  output logic      [capm_pkg::ROOT_W-1:0]    root_o
);

  logic [capm_pkg::AREA_W-1:0] rem_q, rem_d;
  logic [capm_pkg::AREA_W-1:0] root_q, root_d;
  logic [capm_pkg::AREA_W-1:0] bit_q, bit_d;
  logic                        run_q, run_d;
  logic                        done_q, done_d;
  logic [capm_pkg::AREA_W-1:0] trial;

  assign trial = root_q + bit_q;

  always_comb begin
    rem_d  = rem_q;
    root_d = root_q;
    bit_d  = bit_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = value_i;
      root_d = '0;
      bit_d  = capm_pkg::ROOT_FIRST_BIT;
      run_d  = 1'b1;
    end else if (run_q) begin
      if (rem_q >= trial) begin
        rem_d  = rem_q - trial;
        root_d = (root_q >> 1) + bit_q;
      end else begin
        root_d = root_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q == capm_pkg::AREA_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    bit_q  <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = root_q[capm_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

// File: rtl/core/capm_ap_table.sv
// Aperture table memory: one write port, one registered read port.
`default_nettype none

module capm_ap_table #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned DW    = 49
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/capm_dist_unit.sv
// Shared distance test: |d|, squares, then sum against radius squared, three stages.
`default_nettype none

module capm_dist_unit #(
  parameter int unsigned CENTRE_W  = 18,
  parameter int unsigned FRAC_BITS = 4
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              valid_i,
  input  wire logic [CENTRE_W-1:0]               cx_i,
  input  wire logic [CENTRE_W-1:0]               cy_i,
  input  wire logic [capm_pkg::RADIUS_W-1:0]     radius_i,
  input  wire logic [CENTRE_W-1:0]               px_i,
  input  wire logic [CENTRE_W-1:0]               py_i,
  output capm_pkg::dist_stat_t                   stat_o
);

  localparam int unsigned RS_W  = capm_pkg::RADIUS_W + FRAC_BITS;
  localparam int unsigned SQ_W  = 2 * CENTRE_W;
  localparam int unsigned R2_W  = 2 * RS_W;
  localparam int unsigned D2_W  = SQ_W + 1;
  localparam int unsigned CMP_W = (D2_W > R2_W) ? D2_W : R2_W;

  logic                v1_q, v2_q, v3_q;
  logic [CENTRE_W-1:0] dx_q, dy_q, dx_d, dy_d;
  logic [RS_W-1:0]     rs_q;
  logic [SQ_W-1:0]     dx2_q, dy2_q;
  logic [R2_W-1:0]     rs2_q;
  logic [CMP_W-1:0]    sum;
  logic                hit_q;

  assign dx_d = (px_i >= cx_i) ? (px_i - cx_i) : (cx_i - px_i);
  assign dy_d = (py_i >= cy_i) ? (py_i - cy_i) : (cy_i - py_i);
  assign sum  = CMP_W'(dx2_q) + CMP_W'(dy2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    rs_q  <= RS_W'(radius_i) << FRAC_BITS;
    dx2_q <= SQ_W'(dx_q) * SQ_W'(dx_q);
    dy2_q <= SQ_W'(dy_q) * SQ_W'(dy_q);
    rs2_q <= R2_W'(rs_q) * R2_W'(rs_q);
    hit_q <= (sum <= CMP_W'(rs2_q));
  end

  assign stat_o.busy      = v1_q | v2_q | v3_q;
  assign stat_o.hit_valid = v3_q;
  assign stat_o.hit       = hit_q;

endmodule

`default_nettype wire

// File: rtl/core/circular_aperture_pixel_mask_top.sv
// Top level of the circular aperture pixel mask: control, counters, registers.
// Load item: busy through the root steps (12 root steps, one table write); no result.
// Pixel item: one table entry read per cycle, up to the tested aperture count n, feeds
//   the distance pipe; the result strobe follows once that pipe has drained.
// Throughput: one item at a time; start is taken again in the cycle the result shows.
// Reset: async, active low; registers to defaults, counters to zero, table not cleared.
`default_nettype none

module circular_aperture_pixel_mask_top #(
  parameter int unsigned MAX_APERTURES = 64,
  parameter int unsigned COORD_BITS    = 14,
  parameter int unsigned FRAC_BITS     = 4
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // command channel
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [capm_pkg::FUNC_W-1:0]       func_i,
  input  wire logic [capm_pkg::SLOT_W-1:0]       ap_slot_i,
  input  wire logic [capm_pkg::POS_W-1:0]        ap_x_i,
  input  wire logic [capm_pkg::POS_W-1:0]        ap_y_i,
  input  wire logic [capm_pkg::AREA_W-1:0]       ap_area_i,
  input  wire logic [capm_pkg::PIXEL_W-1:0]      pixel_value_i,
  // configuration write port
  input  wire logic                              cfg_we_i,
  input  wire logic [capm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [capm_pkg::CFG_W-1:0]        cfg_wdata_i,
  // results
  output logic                                   result_strobe_o,
  output logic      [capm_pkg::PIXEL_W-1:0]      pixel_out_o,
  output logic                                   kept_o,
  output logic                                   end_of_row_o,
  output logic                                   end_of_frame_o
);

  localparam int unsigned AW       = (MAX_APERTURES > 1) ? $clog2(MAX_APERTURES) : 1;
  localparam int unsigned CW       = $clog2(MAX_APERTURES + 1);
  localparam int unsigned CENTRE_W = COORD_BITS + FRAC_BITS;
  localparam int unsigned ENTRY_W  = 2 * CENTRE_W + capm_pkg::RADIUS_W;
  localparam int unsigned LW       = COORD_BITS + 1;
  localparam int unsigned LIMIT    = 1 << COORD_BITS;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [capm_pkg::SIZE_W-1:0]   width_q, height_q;
  logic [capm_pkg::COUNT_W-1:0]  ap_count_q;
  logic [capm_pkg::RADIUS_W-1:0] min_rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= capm_pkg::SIZE_RESET;
      height_q   <= capm_pkg::SIZE_RESET;
      ap_count_q <= capm_pkg::COUNT_RESET;
      min_rad_q  <= capm_pkg::MIN_RADIUS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        capm_pkg::REG_IMAGE_WIDTH:    width_q    <= cfg_wdata_i[capm_pkg::SIZE_W-1:0];
        capm_pkg::REG_IMAGE_HEIGHT:   height_q   <= cfg_wdata_i[capm_pkg::SIZE_W-1:0];
        capm_pkg::REG_APERTURE_COUNT: ap_count_q <= cfg_wdata_i[capm_pkg::COUNT_W-1:0];
        capm_pkg::REG_MIN_RADIUS:     min_rad_q  <= cfg_wdata_i[capm_pkg::RADIUS_W-1:0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Control state and item holding registers
  // ---------------------------------------------------------------------------
  capm_pkg::state_e state_q, state_d;

  logic                          accept;
  logic                          slot_ok;
  logic                          load_go;
  logic                          pix_go;
  logic [31:0]                   slot_wide;
  logic [AW-1:0]                 slot_q;
  logic [CENTRE_W-1:0]           ap_x_q, ap_y_q;
  logic [capm_pkg::PIXEL_W-1:0]  pix_q;
  logic [CW-1:0]                 k_q, k_d;
  logic [CW-1:0]                 n_q, n_d;
  logic                          rd_en;
  logic                          rd_valid_q;
  logic                          kept_q, kept_d;
  logic                          finish;

  // Root unit and radius
  logic                          root_done;
  logic [capm_pkg::ROOT_W-1:0]   root;
  logic [capm_pkg::RADIUS_W-1:0] rad_raw, rad;
  logic                          tbl_we;

  // Table read side
  logic [ENTRY_W-1:0]            rd_entry;
  logic [CENTRE_W-1:0]           rd_cx, rd_cy;
  logic [capm_pkg::RADIUS_W-1:0] rd_rad;
  capm_pkg::dist_stat_t          dstat;

  // Raster position
  logic [COORD_BITS-1:0]         col_q, col_d, row_q, row_d;
  logic [LW-1:0]                 w_cl, h_cl, col_p1, row_p1;
  logic                          eor, eof;
  logic [CENTRE_W-1:0]           px, py;

  assign accept    = start & ~busy;
  assign slot_wide = 32'(ap_slot_i);
  assign slot_ok   = slot_wide < MAX_APERTURES;
  // out-of-range slot loads are simply dropped, block stays idle
  assign load_go   = accept & (func_i == capm_pkg::FUNC_LOAD) & slot_ok;
  assign pix_go    = accept & (func_i == capm_pkg::FUNC_PIXEL);

  // Tested count saturates at the table depth
  assign n_d = (32'(ap_count_q) > MAX_APERTURES) ? CW'(MAX_APERTURES) : CW'(ap_count_q);

  // All entries issued and the read/distance pipe has drained
  assign finish = (k_q == n_q) & ~rd_valid_q & ~dstat.busy;

  always_comb begin
    state_d = state_q;
    rd_en   = 1'b0;
    k_d     = k_q;
    kept_d  = kept_q;
    case (state_q)
      capm_pkg::ST_IDLE: begin
        if (load_go) begin
          state_d = capm_pkg::ST_ROOT;
        end else if (pix_go) begin
          state_d = capm_pkg::ST_PIX;
          k_d     = '0;
          kept_d  = 1'b0;
        end
      end
      capm_pkg::ST_ROOT: begin
        if (root_done) begin
          state_d = capm_pkg::ST_IDLE;
        end
      end
      capm_pkg::ST_PIX: begin
        if (k_q != n_q) begin
          rd_en = 1'b1;
          k_d   = k_q + CW'(1);
        end
        if (dstat.hit_valid && dstat.hit) begin
          kept_d = 1'b1;
        end
        if (finish) begin
          state_d = capm_pkg::ST_IDLE;
        end
      end
      default: state_d = capm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= capm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q        <= '0;
      kept_q     <= 1'b0;
      rd_valid_q <= 1'b0;
    end else begin
      k_q        <= k_d;
      kept_q     <= kept_d;
      rd_valid_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot_q <= slot_wide[AW-1:0];
      ap_x_q <= CENTRE_W'(ap_x_i);
      ap_y_q <= CENTRE_W'(ap_y_i);
      pix_q  <= pixel_value_i;
      n_q    <= n_d;
    end
  end

  assign busy = (state_q != capm_pkg::ST_IDLE);

  // ---------------------------------------------------------------------------
  // Load path: radius = isqrt(area) + 1, floored at min_radius
  // ---------------------------------------------------------------------------
  capm_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (load_go),
    .value_i (ap_area_i),
    .done_o  (root_done),
    .root_o  (root)
  );

  assign rad_raw = capm_pkg::RADIUS_W'(root) + capm_pkg::RADIUS_W'(1);
  assign rad     = (rad_raw < min_rad_q) ? min_rad_q : rad_raw;
  assign tbl_we  = (state_q == capm_pkg::ST_ROOT) & root_done;

  capm_ap_table #(
    .DEPTH (MAX_APERTURES),
    .AW    (AW),
    .DW    (ENTRY_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (slot_q),
    .wdata_i ({ap_x_q, ap_y_q, rad}),
    .raddr_i (k_q[AW-1:0]),
    .rdata_o (rd_entry)
  );

  assign {rd_cx, rd_cy, rd_rad} = rd_entry;

  // ---------------------------------------------------------------------------
  // Pixel path: one entry per cycle through the shared distance unit
  // ---------------------------------------------------------------------------
  assign px = CENTRE_W'(col_q) << FRAC_BITS;
  assign py = CENTRE_W'(row_q) << FRAC_BITS;

  capm_dist_unit #(
    .CENTRE_W  (CENTRE_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (rd_valid_q),
    .cx_i     (rd_cx),
    .cy_i     (rd_cy),
    .radius_i (rd_rad),
    .px_i     (px),
    .py_i     (py),
    .stat_o   (dstat)
  );

  // Frame size clamped to 1 .. 2^COORD_BITS
  always_comb begin
    if (width_q == '0) begin
      w_cl = LW'(1);
    end else if (32'(width_q) > LIMIT) begin
      w_cl = LW'(LIMIT);
    end else begin
      w_cl = LW'(width_q);
    end
    if (height_q == '0) begin
      h_cl = LW'(1);
    end else if (32'(height_q) > LIMIT) begin
      h_cl = LW'(LIMIT);
    end else begin
      h_cl = LW'(height_q);
    end
  end

  assign col_p1 = LW'(col_q) + LW'(1);
  assign row_p1 = LW'(row_q) + LW'(1);
  assign eor    = col_p1 >= w_cl;   // also catches a counter past a shrunk width
  assign eof    = eor & (row_p1 >= h_cl);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (state_q == capm_pkg::ST_PIX && finish) begin
      if (eor) begin
        col_d = '0;
        row_d = eof ? '0 : row_p1[COORD_BITS-1:0];
      end else begin
        col_d = col_p1[COORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic                         res_strobe_q;
  logic [capm_pkg::PIXEL_W-1:0] res_pix_q;
  logic                         res_kept_q, res_eor_q, res_eof_q;
  logic                         emit;

  assign emit = (state_q == capm_pkg::ST_PIX) & finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_strobe_q <= 1'b0;
    end else begin
      res_strobe_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_pix_q  <= kept_q ? pix_q : '0;
      res_kept_q <= kept_q;
      res_eor_q  <= eor;
      res_eof_q  <= eof;
    end
  end

  assign result_strobe_o = res_strobe_q;
  assign pixel_out_o     = res_pix_q;
  assign kept_o          = res_kept_q;
  assign end_of_row_o    = res_eor_q;
  assign end_of_frame_o  = res_eof_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_strobe_from_pix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(state_q == capm_pkg::ST_PIX))
    else $error("result strobe without a pixel in flight");

  a_eof_has_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && end_of_frame_o) |-> end_of_row_o)
    else $error("end of frame without end of row");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (k_q < n_q))
    else $error("table read beyond tested count");

  a_load_enters_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_go |=> (state_q == capm_pkg::ST_ROOT))
    else $error("load did not start the root unit");

  a_write_only_in_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_done |-> (state_q == capm_pkg::ST_ROOT))
    else $error("root finished outside a load");

endmodule

`default_nettype wire

// File: sim/tb_circular_aperture_pixel_mask_top.sv
// Self-checking testbench for the circular aperture pixel mask top level.
`timescale 1ns / 1ps

module tb_circular_aperture_pixel_mask_top;

  localparam int unsigned MAX_APERTURES = 64;
  localparam int unsigned COORD_BITS    = 14;
  localparam int unsigned FRAC_BITS     = 4;
  localparam int unsigned SIDE_LIMIT    = 1 << COORD_BITS;
  localparam int unsigned ITEMS_TOTAL   = 1350;
  // loads keep busy high through the root steps and make no result, so settle past that
  localparam int unsigned SETTLE_CYCLES = 24;
  // worst pixel: all 64 apertures tested, plus the sender's longest random gap
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;

  typedef struct packed {
    logic [capm_pkg::FUNC_W-1:0]  func;
    logic [capm_pkg::SLOT_W-1:0]  slot;
    logic [capm_pkg::POS_W-1:0]   x;
    logic [capm_pkg::POS_W-1:0]   y;
    logic [capm_pkg::AREA_W-1:0]  area;
    logic [capm_pkg::PIXEL_W-1:0] pix;
  } mask_item_t;

  typedef struct packed {
    logic [capm_pkg::PIXEL_W-1:0] pix;
    logic                         kept;
    logic                         eor;
    logic                         eof;
  } masked_pixel_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // DUT inputs, all known from time zero
  logic                           start         = 1'b0;
  logic [capm_pkg::FUNC_W-1:0]    func_i        = capm_pkg::FUNC_LOAD;
  logic [capm_pkg::SLOT_W-1:0]    ap_slot_i     = '0;
  logic [capm_pkg::POS_W-1:0]     ap_x_i        = '0;
  logic [capm_pkg::POS_W-1:0]     ap_y_i        = '0;
  logic [capm_pkg::AREA_W-1:0]    ap_area_i     = '0;
  logic [capm_pkg::PIXEL_W-1:0]   pixel_value_i = '0;
  logic                           cfg_we_i      = 1'b0;
  logic [capm_pkg::CFG_IDX_W-1:0] cfg_idx_i     = capm_pkg::REG_IMAGE_WIDTH;
  logic [capm_pkg::CFG_W-1:0]     cfg_wdata_i   = '0;

  logic                           busy;
  logic                           result_strobe_o;
  logic [capm_pkg::PIXEL_W-1:0]   pixel_out_o;
  logic                           kept_o;
  logic                           end_of_row_o;
  logic                           end_of_frame_o;

  circular_aperture_pixel_mask_top #(
    .MAX_APERTURES(MAX_APERTURES),
    .COORD_BITS   (COORD_BITS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .ap_slot_i      (ap_slot_i),
    .ap_x_i         (ap_x_i),
    .ap_y_i         (ap_y_i),
    .ap_area_i      (ap_area_i),
    .pixel_value_i  (pixel_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_strobe_o(result_strobe_o),
    .pixel_out_o    (pixel_out_o),
    .kept_o         (kept_o),
    .end_of_row_o   (end_of_row_o),
    .end_of_frame_o (end_of_frame_o)
  );

  // ---------------------------------------------------------------------------
  // Mask predictor: own copy of the registers, aperture table and raster counters
  // ---------------------------------------------------------------------------
  logic [capm_pkg::SIZE_W-1:0]   img_w    = capm_pkg::SIZE_RESET;
  logic [capm_pkg::SIZE_W-1:0]   img_h    = capm_pkg::SIZE_RESET;
  logic [capm_pkg::COUNT_W-1:0]  ap_count = capm_pkg::COUNT_RESET;
  logic [capm_pkg::RADIUS_W-1:0] min_rad  = capm_pkg::MIN_RADIUS_RESET;

  logic [capm_pkg::POS_W-1:0]    ap_cx  [MAX_APERTURES];
  logic [capm_pkg::POS_W-1:0]    ap_cy  [MAX_APERTURES];
  logic [capm_pkg::RADIUS_W-1:0] ap_rad [MAX_APERTURES];
  logic [COORD_BITS-1:0]         col_pos = '0;
  logic [COORD_BITS-1:0]         row_pos = '0;

  mask_item_t    pending_q[$];   // items waiting to be driven
  masked_pixel_t due_q[$];       // predicted pixels not yet seen on the outputs

  int unsigned items_queued = 0;
  int unsigned loads_taken  = 0;
  int unsigned pixels_taken = 0;
  int unsigned kept_seen    = 0;
  int unsigned rows_seen    = 0;
  int unsigned frames_seen  = 0;
  int unsigned pixels_out   = 0;
  int unsigned cfg_writes   = 0;
  int unsigned phases       = 0;
  int unsigned errors       = 0;
  int unsigned cycles       = 0;

  // integer square root of the area, bit by bit from the top
  function automatic logic [capm_pkg::ROOT_W-1:0] area_root(
      input logic [capm_pkg::AREA_W-1:0] a);
    logic [capm_pkg::ROOT_W-1:0] r;
    logic [capm_pkg::ROOT_W-1:0] t;
    r = '0;
    for (int b = capm_pkg::ROOT_W - 1; b >= 0; b--) begin
      t = r | (capm_pkg::ROOT_W'(1) << b);
      if (32'(t) * 32'(t) <= 32'(a)) r = t;
    end
    return r;
  endfunction

  function automatic void mask_step(input mask_item_t it);
    logic [capm_pkg::RADIUS_W-1:0] rad;
    longint unsigned               wd, ht, px, py, dx, dy, rs;
    int unsigned                   lim;
    logic                          hit, eor, eof;
    masked_pixel_t                 res;
    if (it.func == capm_pkg::FUNC_LOAD) begin
      rad = capm_pkg::RADIUS_W'(area_root(it.area)) + 1'b1;
      if (rad < min_rad) rad = min_rad;
      ap_cx[it.slot]  = it.x;
      ap_cy[it.slot]  = it.y;
      ap_rad[it.slot] = rad;
      loads_taken++;
      return;
    end
    // zero size counts as one, oversize saturates at the counter range
    wd  = (img_w == 0) ? 1 : (img_w > SIDE_LIMIT) ? SIDE_LIMIT : img_w;
    ht  = (img_h == 0) ? 1 : (img_h > SIDE_LIMIT) ? SIDE_LIMIT : img_h;
    lim = (ap_count > MAX_APERTURES) ? MAX_APERTURES : ap_count;
    px  = 64'(col_pos) << FRAC_BITS;
    py  = 64'(row_pos) << FRAC_BITS;
    hit = 1'b0;
    for (int k = 0; k < lim; k++) begin
      dx = (px >= ap_cx[k]) ? px - ap_cx[k] : ap_cx[k] - px;
      dy = (py >= ap_cy[k]) ? py - ap_cy[k] : ap_cy[k] - py;
      rs = 64'(ap_rad[k]) << FRAC_BITS;
      if (dx * dx + dy * dy <= rs * rs) hit = 1'b1;
    end
    // a counter at or past a shrunken size closes its row or frame here
    eor = (64'(col_pos) + 1 >= wd);
    eof = eor && (64'(row_pos) + 1 >= ht);
    res.pix  = hit ? it.pix : '0;
    res.kept = hit;
    res.eor  = eor;
    res.eof  = eof;
    due_q.push_back(res);
    if (eor) begin
      col_pos = '0;
      row_pos = eof ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    pixels_taken++;
    kept_seen   += hit;
    rows_seen   += eor;
    frames_seen += eof;
  endfunction

  function automatic mask_item_t load_item(input logic [capm_pkg::SLOT_W-1:0] slot,
                                           input logic [capm_pkg::POS_W-1:0]  x,
                                           input logic [capm_pkg::POS_W-1:0]  y,
                                           input logic [capm_pkg::AREA_W-1:0] area);
    mask_item_t it;
    it.func = capm_pkg::FUNC_LOAD;
    it.slot = slot;
    it.x    = x;
    it.y    = y;
    it.area = area;
    it.pix  = capm_pkg::PIXEL_W'($urandom);
    return it;
  endfunction

  function automatic mask_item_t pixel_item(input logic [capm_pkg::PIXEL_W-1:0] value);
    mask_item_t it;
    it.func = capm_pkg::FUNC_PIXEL;
    it.slot = capm_pkg::SLOT_W'($urandom);
    it.x    = capm_pkg::POS_W'($urandom);
    it.y    = capm_pkg::POS_W'($urandom);
    it.area = capm_pkg::AREA_W'($urandom);
    it.pix  = value;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of items with random gaps; an item is taken on start && !busy
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin : drive
    bit took;
    if (rst_ni) begin
      took = start && !busy;
      if (took) begin
        mask_step(pending_q[0]);
        void'(pending_q.pop_front());
      end
      if (start && !took) begin
        // item still on offer, hold everything
      end else if (gap_left != 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (pending_q.size() != 0) begin
        start         <= 1'b1;
        func_i        <= pending_q[0].func;
        ap_slot_i     <= pending_q[0].slot;
        ap_x_i        <= pending_q[0].x;
        ap_y_i        <= pending_q[0].y;
        ap_area_i     <= pending_q[0].area;
        pixel_value_i <= pending_q[0].pix;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(30, 1);
          // long stretches without idling, short gaps, the odd long pause
          case ($urandom_range(9, 0))
            0, 1, 2, 3: gap_left = 0;
            8:          gap_left = $urandom_range(80, 20);
            9:          gap_left = $urandom_range(3, 1);
            default:    gap_left = $urandom_range(8, 1);
          endcase
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed pixel against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check
    masked_pixel_t want;
    if (rst_ni && result_strobe_o) begin
      pixels_out++;
      if (due_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected pixel: pixel_out %h kept %b eor %b eof %b",
                   pixel_out_o, kept_o, end_of_row_o, end_of_frame_o);
      end else begin
        want = due_q.pop_front();
        if (pixel_out_o !== want.pix || kept_o !== want.kept ||
            end_of_row_o !== want.eor || end_of_frame_o !== want.eof) begin
          errors++;
          if (errors <= 10)
            $display("pixel %0d mismatch: pixel_out %h/%h kept %b/%b eor %b/%b eof %b/%b",
                     pixels_out, want.pix, pixel_out_o, want.kept, kept_o,
                     want.eor, end_of_row_o, want.eof, end_of_frame_o);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels outstanding", cycles, due_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing: registers change only with the block idle
  // ---------------------------------------------------------------------------
  task automatic set_reg(input logic [capm_pkg::CFG_IDX_W-1:0] idx,
                         input logic [capm_pkg::CFG_W-1:0]     val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      capm_pkg::REG_IMAGE_WIDTH:    img_w    = val[capm_pkg::SIZE_W-1:0];
      capm_pkg::REG_IMAGE_HEIGHT:   img_h    = val[capm_pkg::SIZE_W-1:0];
      capm_pkg::REG_APERTURE_COUNT: ap_count = val[capm_pkg::COUNT_W-1:0];
      capm_pkg::REG_MIN_RADIUS:     min_rad  = val[capm_pkg::RADIUS_W-1:0];
      default: ;  // unmapped index, the block ignores it
    endcase
    cfg_writes++;
  endtask

  // the sender pauses here until every predicted pixel has come out
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || start || busy || due_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    phases++;
  endtask

  initial begin : run
    int unsigned w, h, cnt, mr, n, xs, ys;
    logic [capm_pkg::POS_W-1:0] cx, cy;
    logic [capm_pkg::AREA_W-1:0] area;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: no aperture tested, so both pixels come out as zero.
    // Far-corner loads: one raised to the reset minimum radius, one at full area.
    pending_q.push_back(pixel_item('1));
    pending_q.push_back(pixel_item('0));
    pending_q.push_back(load_item(capm_pkg::SLOT_W'(MAX_APERTURES - 2), '1, '0, '0));
    pending_q.push_back(load_item(capm_pkg::SLOT_W'(MAX_APERTURES - 1), '1, '1, '1));
    items_queued += 4;
    wait_idle();

    // Small frame, exact radius edges around a few hand-placed centres
    set_reg(capm_pkg::REG_MIN_RADIUS, '0);
    set_reg(capm_pkg::REG_IMAGE_WIDTH, 15'd6);
    set_reg(capm_pkg::REG_IMAGE_HEIGHT, 15'd3);
    set_reg(capm_pkg::REG_APERTURE_COUNT, 15'd4);
    @(negedge clk_i);
    pending_q.push_back(load_item(capm_pkg::SLOT_W'(0), '0, '0, '0));
    pending_q.push_back(load_item(capm_pkg::SLOT_W'(1),
                                  capm_pkg::POS_W'((4 << FRAC_BITS) | 8),
                                  capm_pkg::POS_W'(1 << FRAC_BITS),
                                  capm_pkg::AREA_W'(3)));
    pending_q.push_back(load_item(capm_pkg::SLOT_W'(2),
                                  capm_pkg::POS_W'(2 << FRAC_BITS),
                                  capm_pkg::POS_W'((2 << FRAC_BITS) | 15), '0));
    pending_q.push_back(load_item(capm_pkg::SLOT_W'(3), '1,
                                  capm_pkg::POS_W'(1 << FRAC_BITS),
                                  capm_pkg::AREA_W'(8)));
    // fill the rest of the table so any later aperture count reads written entries
    for (int s = 4; s < MAX_APERTURES - 2; s++)
      pending_q.push_back(load_item(capm_pkg::SLOT_W'(s),
                                    capm_pkg::POS_W'(($urandom_range(30, 0) << FRAC_BITS) |
                                                     $urandom_range(15, 0)),
                                    capm_pkg::POS_W'(($urandom_range(20, 0) << FRAC_BITS) |
                                                     $urandom_range(15, 0)),
                                    capm_pkg::AREA_W'($urandom_range(40, 0))));
    for (int p = 0; p < 18; p++)
      pending_q.push_back(pixel_item(capm_pkg::PIXEL_W'((p % 3 == 0) ? 16'hFFFF :
                                                        (p % 3 == 1) ? 16'hAAAA :
                                                                       16'h5555)));
    items_queued += MAX_APERTURES - 2 + 18;
    wait_idle();

    // Zero sizes act as one, oversized count saturates, widest minimum radius
    set_reg(capm_pkg::REG_IMAGE_WIDTH, '0);
    set_reg(capm_pkg::REG_IMAGE_HEIGHT, '0);
    set_reg(capm_pkg::REG_APERTURE_COUNT, 15'(7'h7F));
    set_reg(capm_pkg::REG_MIN_RADIUS, 15'(13'h1FFF));
    @(negedge clk_i);
    pending_q.push_back(load_item(capm_pkg::SLOT_W'(MAX_APERTURES - 1), '1, '1, '0));
    pending_q.push_back(pixel_item(16'h8001));
    pending_q.push_back(pixel_item(16'h7FFE));
    items_queued += 3;
    wait_idle();

    // Oversized width and largest legal sizes; minimum radius at the largest radius the root can give
    set_reg(capm_pkg::REG_IMAGE_WIDTH, 15'h7FFF);
    set_reg(capm_pkg::REG_IMAGE_HEIGHT, 15'(SIDE_LIMIT));
    set_reg(capm_pkg::REG_APERTURE_COUNT, 15'(MAX_APERTURES));
    set_reg(capm_pkg::REG_MIN_RADIUS, 15'd4096);
    @(negedge clk_i);
    pending_q.push_back(load_item(capm_pkg::SLOT_W'(MAX_APERTURES - 2), '1, '0, '0));
    pending_q.push_back(pixel_item(16'h0001));
    pending_q.push_back(pixel_item(16'hFFFE));
    items_queued += 3;

    // Random phases: mostly small frames so rows and frames close often,
    // apertures placed around the visible area with small radii.
    while (items_queued < ITEMS_TOTAL) begin
      wait_idle();
      case ($urandom_range(9, 0))
        0:       w = 0;
        1:       w = SIDE_LIMIT;
        2:       w = $urandom_range(32767, SIDE_LIMIT + 1);
        default: w = $urandom_range(24, 1);
      endcase
      case ($urandom_range(9, 0))
        0:       h = 0;
        1:       h = SIDE_LIMIT;
        2:       h = $urandom_range(32767, SIDE_LIMIT + 1);
        default: h = $urandom_range(12, 1);
      endcase
      case ($urandom_range(19, 0))
        0, 1:    cnt = 0;
        2, 3, 4: cnt = MAX_APERTURES;
        5, 6:    cnt = $urandom_range(127, MAX_APERTURES + 1);
        default: cnt = $urandom_range(MAX_APERTURES, 1);
      endcase
      case ($urandom_range(19, 0))
        0:       mr = 4096;
        1:       mr = 8191;
        2:       mr = $urandom_range(8191, 0);
        3:       mr = $urandom_range(40, 5);
        default: mr = $urandom_range(4, 0);
      endcase
      // unused upper data bits carry noise that the narrow registers drop
      set_reg(capm_pkg::REG_IMAGE_WIDTH, 15'(w));
      set_reg(capm_pkg::REG_IMAGE_HEIGHT, 15'(h));
      set_reg(capm_pkg::REG_APERTURE_COUNT,
              15'(($urandom_range(255, 0) << capm_pkg::COUNT_W) | cnt));
      set_reg(capm_pkg::REG_MIN_RADIUS,
              15'(($urandom_range(3, 0) << capm_pkg::RADIUS_W) | mr));
      if ($urandom_range(3, 0) == 0)
        for (int i = capm_pkg::REG_MIN_RADIUS + 1; i < (1 << capm_pkg::CFG_IDX_W); i++)
          set_reg(capm_pkg::CFG_IDX_W'(i), capm_pkg::CFG_W'($urandom));
      xs = (w == 0 || w > 64) ? 40 : w;
      ys = (h == 0 || h > 64) ? 20 : h;
      n  = $urandom_range(120, 30);
      @(negedge clk_i);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(99, 0) < 15) begin
          if ($urandom_range(9, 0) == 0) begin
            cx = capm_pkg::POS_W'($urandom);
            cy = capm_pkg::POS_W'($urandom);
          end else begin
            cx = capm_pkg::POS_W'(($urandom_range(xs + 4, 0) << FRAC_BITS) |
                                  $urandom_range(15, 0));
            cy = capm_pkg::POS_W'(($urandom_range(ys + 4, 0) << FRAC_BITS) |
                                  $urandom_range(15, 0));
          end
          area = ($urandom_range(19, 0) == 0) ? capm_pkg::AREA_W'($urandom)
                                               : capm_pkg::AREA_W'($urandom_range(60, 0));
          pending_q.push_back(load_item(capm_pkg::SLOT_W'($urandom), cx, cy, area));
        end else begin
          pending_q.push_back(pixel_item(capm_pkg::PIXEL_W'($urandom)));
        end
      end
      items_queued += n;
    end

    wait_idle();
    repeat (80) @(posedge clk_i);
    if (due_q.size() != 0) begin
      errors += due_q.size();
      $display("%0d predicted pixels never appeared", due_q.size());
    end

    $display("covered: %0d pixels (%0d kept, %0d row ends, %0d frame ends), %0d loads",
             pixels_taken, kept_seen, rows_seen, frames_seen, loads_taken);
    $display("covered: %0d register writes over %0d idle phases in %0d cycles, %0d errors",
             cfg_writes, phases, cycles, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
